### sv/ice_pkg.sv
package ice_pkg;

	localparam int LANE_BYTES  = 8;
	localparam int DATA_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int LEN_W       = 16;
	localparam int WORD_W      = 16;
	localparam int ACC_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int LANE_SUM_W  = $clog2((LANE_BYTES / 2) * 255 + 1);
	localparam int VAL_W       = 21;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic             first;
		logic             last;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

### sv/ice_in_if.sv
interface ice_in_if;

	logic        valid;
	logic        ready;
	logic [63:0] data;
	logic [3:0]  byte_count;
	logic        first;
	logic        last;
	logic [31:0] seed_sum;
	logic        pseudo_enable;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [7:0]  protocol_number;

	modport source (
		output valid, data, byte_count, first, last, seed_sum, pseudo_enable,
		       source_address, destination_address, protocol_number,
		input  ready
	);

	modport sink (
		input  valid, data, byte_count, first, last, seed_sum, pseudo_enable,
		       source_address, destination_address, protocol_number,
		output ready
	);

endinterface

### sv/ice_out_if.sv
interface ice_out_if;

	logic        valid;
	logic        ready;
	logic [15:0] checksum;
	logic [15:0] folded_sum;

	modport source (
		output valid, checksum, folded_sum,
		input  ready
	);

	modport sink (
		input  valid, checksum, folded_sum,
		output ready
	);

endinterface

### sv/ice_front.sv
module ice_front (
	input  logic            clk,
	input  logic            arst_n,
	ice_in_if.sink          pkt,
	input  logic            q_full,
	output logic            push,
	output ice_pkg::entry_t push_entry
);

	logic                                       off_q;
	logic [ice_pkg::LEN_W-1:0]                  len_q;
	logic                                       base_off;
	logic [ice_pkg::LEN_W-1:0]                  base_len;
	logic [ice_pkg::COUNT_W-1:0]                eff_count;
	logic [ice_pkg::LEN_W-1:0]                  len_new;
	logic [ice_pkg::LANE_SUM_W-1:0]             even_sum;
	logic [ice_pkg::LANE_SUM_W-1:0]             odd_sum;
	logic [ice_pkg::VAL_W-1:0]                  item_val;
	logic [ice_pkg::VAL_W-1:0]                  seed_val;
	logic [ice_pkg::VAL_W-1:0]                  pseudo_val;

	assign pkt.ready = !q_full;
	assign push      = pkt.valid && !q_full;

	assign base_off  = pkt.first ? 1'b0 : off_q;
	assign base_len  = pkt.first ? '0 : len_q;
	assign eff_count = (pkt.byte_count > ice_pkg::COUNT_W'(ice_pkg::LANE_BYTES)) ?
		ice_pkg::COUNT_W'(ice_pkg::LANE_BYTES) : pkt.byte_count;
	assign len_new   = base_len + ice_pkg::LEN_W'(eff_count);

	// lane sums split by parity of lane index
	always_comb begin
		even_sum = '0;
		odd_sum  = '0;
		for (int i = 0; i < ice_pkg::LANE_BYTES; i++) begin
			if (ice_pkg::COUNT_W'(i) < eff_count) begin
				if ((i % 2) == 0) begin
					even_sum = even_sum + ice_pkg::LANE_SUM_W'(pkt.data[i*8 +: 8]);
				end else begin
					odd_sum = odd_sum + ice_pkg::LANE_SUM_W'(pkt.data[i*8 +: 8]);
				end
			end
		end
	end

	always_comb begin
		if (base_off) begin
			item_val = ice_pkg::VAL_W'({odd_sum, 8'b0}) + ice_pkg::VAL_W'(even_sum);
		end else begin
			item_val = ice_pkg::VAL_W'({even_sum, 8'b0}) + ice_pkg::VAL_W'(odd_sum);
		end
	end

	assign seed_val = pkt.first ?
		(ice_pkg::VAL_W'(pkt.seed_sum[31:16]) + ice_pkg::VAL_W'(pkt.seed_sum[15:0])) : '0;

	assign pseudo_val = (pkt.last && pkt.pseudo_enable) ?
		(ice_pkg::VAL_W'(pkt.source_address[31:16])
		+ ice_pkg::VAL_W'(pkt.source_address[15:0])
		+ ice_pkg::VAL_W'(pkt.destination_address[31:16])
		+ ice_pkg::VAL_W'(pkt.destination_address[15:0])
		+ ice_pkg::VAL_W'(pkt.protocol_number)
		+ ice_pkg::VAL_W'(len_new)) : '0;

	assign push_entry.first = pkt.first;
	assign push_entry.last  = pkt.last;
	assign push_entry.value = item_val + seed_val + pseudo_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 1'b0;
			len_q <= '0;
		end else if (push) begin
			if (pkt.last) begin
				off_q <= 1'b0;
				len_q <= '0;
			end else begin
				off_q <= base_off ^ eff_count[0];
				len_q <= len_new;
			end
		end
	end

endmodule

### sv/ice_queue.sv
module ice_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ice_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ice_pkg::entry_t head_entry
);

	ice_pkg::entry_t              mem_q [ice_pkg::QUEUE_DEPTH];
	logic [ice_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [ice_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [ice_pkg::QUEUE_AW:0]   cnt_q;
	logic                         do_pop;

	assign full       = (cnt_q == (ice_pkg::QUEUE_AW+1)'(ice_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/ice_back.sv
module ice_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  ice_pkg::entry_t head_entry,
	output logic            pop,
	ice_out_if.source       res
);

	logic [ice_pkg::ACC_W-1:0]    acc_q;
	logic [ice_pkg::ACC_W-1:0]    out_sum_q;
	logic                         out_valid_q;
	logic                         load_ok;
	logic [ice_pkg::ACC_W-1:0]    base;
	logic [ice_pkg::ACC_W:0]      raw_sum;
	logic [ice_pkg::ACC_W-1:0]    acc_new;
	logic [ice_pkg::WORD_W:0]     fold1;
	logic [ice_pkg::WORD_W-1:0]   fold2;

	assign load_ok = !out_valid_q || res.ready;
	assign pop     = head_valid && (!head_entry.last || load_ok);

	// end-around carry add
	assign base    = head_entry.first ? '0 : acc_q;
	assign raw_sum = {1'b0, base} + (ice_pkg::ACC_W+1)'(head_entry.value);
	assign acc_new = raw_sum[ice_pkg::ACC_W-1:0] + ice_pkg::ACC_W'(raw_sum[ice_pkg::ACC_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head_entry.last ? '0 : acc_new;
			end
			if (pop && head_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_entry.last) begin
			out_sum_q <= acc_new;
		end
	end

	// fold to 16 bits
	assign fold1 = (ice_pkg::WORD_W+1)'(out_sum_q[31:16])
		+ (ice_pkg::WORD_W+1)'(out_sum_q[15:0]);
	assign fold2 = fold1[ice_pkg::WORD_W-1:0] + ice_pkg::WORD_W'(fold1[ice_pkg::WORD_W]);

	assign res.valid      = out_valid_q;
	assign res.folded_sum = fold2;
	assign res.checksum   = ~fold2;

endmodule

### sv/internet_checksum_engine_unit.sv
// channel | dir | beat
// pkt     | in  | up to 8 packet bytes, first/last marks, seed, pseudo-header fields
// res     | out | checksum and folded sum, one beat per packet
//
// one beat per cycle on pkt while the queue is not full; after its last beat a result
// passes the queue entry and then the back output register before it leaves
// arst_n clears offset, length, accumulator, queue and output valid
// a four-entry queue parts front and back; a stalled res only holds up last beats
// at the head of the queue, pkt stalls when the queue is full
module internet_checksum_engine_unit (
	input  logic     clk,
	input  logic     arst_n,
	ice_in_if.sink   pkt,
	ice_out_if.source res
);

	logic            q_full;
	logic            push;
	ice_pkg::entry_t push_entry;
	logic            pop;
	logic            head_valid;
	ice_pkg::entry_t head_entry;

	ice_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ice_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	ice_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res        (res)
	);

endmodule
